// ===== rtl/cpf_pkg.sv =====
// Shared types, constants and the byte-wide CRC update for the packet framer.
package cpf_pkg;

    localparam int BURST_MAX   = 12;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
    localparam int PREAMBLE_LEN = 4;
    localparam int HDR_LEN     = 10;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  PREAMBLE_BYTE = 8'hFF;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_FRAME = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        status_t    result_status;
    } out_item_t;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] v;
        v = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (v[15])
            begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/crc16_packet_framer_core.sv =====
// Each accepted request becomes a burst of output beats, one per cycle while out_ready is high:
// a mid-frame payload byte gives one beat, the last payload byte three (byte and two CRC bytes),
// a start gives ten header beats (twelve for an empty frame) and an error gives one. The framing
// state and CRC are updated in the cycle a request is accepted, and the next request is taken
// in the same cycle the last beat of the previous burst leaves, so payload streams at one byte per
// cycle unless stalled. The output side alone sets the pace. There is no clearing pass after reset.
module crc16_packet_framer_core
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpf_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpf_pkg::out_item_t  out_data
);
    import cpf_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [31:0] sync_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] left_reg;
    logic [15:0] left_next;

    logic                      load;
    logic                      can_load;
    out_item_t [BURST_MAX-1:0] items;
    logic [BURST_CNT_W-1:0]    item_count;
    logic [15:0]               crc_len;
    logic [15:0]               crc_pay;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign load      = in_valid && can_load;

    assign crc_len = crc16_byte(crc16_byte(CRC_INIT, in_data.frame_length[15:8]),
                                in_data.frame_length[7:0]);
    assign crc_pay = crc16_byte(crc_reg, in_data.payload_byte);

    always_comb
    begin
        items         = '0;
        item_count    = BURST_CNT_W'(1);
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        left_next     = left_reg;
        if (in_data.req_type == REQ_START)
        begin
            // Any open frame is dropped before the new start is handled.
            crc_next      = CRC_INIT;
            in_frame_next = 1'b0;
            left_next     = '0;
            if (in_data.frame_length > MAX_LEN)
            begin
                items[0].out_last      = 1'b1;
                items[0].result_status = ST_TOO_LONG;
            end
            else
            begin
                for (int i = 0; i < PREAMBLE_LEN; i++)
                begin
                    items[i].out_byte = PREAMBLE_BYTE;
                end
                for (int i = 0; i < 4; i++)
                begin
                    items[PREAMBLE_LEN + i].out_byte = sync_reg[8*(3-i) +: 8];
                end
                items[8].out_byte = in_data.frame_length[15:8];
                items[9].out_byte = in_data.frame_length[7:0];
                if (in_data.frame_length == '0)
                begin
                    items[10].out_byte = crc_len[15:8];
                    items[11].out_byte = crc_len[7:0];
                    items[11].out_last = 1'b1;
                    item_count         = BURST_CNT_W'(BURST_MAX);
                end
                else
                begin
                    item_count    = BURST_CNT_W'(HDR_LEN);
                    crc_next      = crc_len;
                    in_frame_next = 1'b1;
                    left_next     = in_data.frame_length;
                end
            end
        end
        else if (!in_frame_reg || (left_reg == '0))
        begin
            items[0].out_last      = 1'b1;
            items[0].result_status = ST_NO_FRAME;
        end
        else
        begin
            items[0].out_byte = in_data.payload_byte;
            left_next         = left_reg - 16'd1;
            if (left_reg == 16'd1)
            begin
                items[1].out_byte = crc_pay[15:8];
                items[2].out_byte = crc_pay[7:0];
                items[2].out_last = 1'b1;
                item_count        = BURST_CNT_W'(3);
                crc_next          = CRC_INIT;
                in_frame_next     = 1'b0;
            end
            else
            begin
                crc_next = crc_pay;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= '0;
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                sync_reg <= cfg_data;
            end
            if (load)
            begin
                crc_reg      <= crc_next;
                in_frame_reg <= in_frame_next;
                left_reg     <= left_next;
            end
        end
    end

    cpf_burst_buf u_burst_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_items (items),
        .load_count (item_count),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== rtl/cpf_burst_buf.sv =====
// Result buffer that holds the bytes caused by one request and sends them one beat at a time.
module cpf_burst_buf
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  cpf_pkg::out_item_t [cpf_pkg::BURST_MAX-1:0] load_items,
    input  logic [cpf_pkg::BURST_CNT_W-1:0]         load_count,
    output logic                                    can_load,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output cpf_pkg::out_item_t                      out_data
);
    import cpf_pkg::*;

    out_item_t [BURST_MAX-1:0] entries_reg;
    out_item_t [BURST_MAX-1:0] entries_next;
    logic [BURST_CNT_W-1:0]    count_reg;
    logic [BURST_CNT_W-1:0]    count_next;
    logic                      pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[0];
    assign pop       = out_valid && out_ready;
    // A new burst may enter in the same cycle the last queued beat leaves.
    assign can_load  = (count_reg == '0) || ((count_reg == BURST_CNT_W'(1)) && out_ready);

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        if (load)
        begin
            entries_next = load_items;
            count_next   = load_count;
        end
        else if (pop)
        begin
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                entries_next[i] = entries_reg[i + 1];
            end
            count_next = count_reg - BURST_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule

// ===== rtl/cpf_checker.sv =====
// Port-level checks for the packet framer, bound to the top level.
module cpf_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input cpf_pkg::in_item_t   in_data,
    input logic                out_valid,
    input logic                out_ready,
    input cpf_pkg::out_item_t  out_data
);
    import cpf_pkg::*;

    // A stalled output beat must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // Every accepted request shows its first beat in the next cycle.
    a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request produced no beat");

    // No new request may enter while the output is stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted over a stalled burst");

    // Error results always end their burst.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_status != ST_OK) |-> out_data.out_last)
        else $error("error result without last flag");

    // An error beat after a byte request can only come from a byte outside a frame.
    a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == REQ_BYTE)
        |=> out_data.result_status != ST_TOO_LONG)
        else $error("length error after a payload byte");

endmodule

bind crc16_packet_framer_core cpf_checker u_cpf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
